// File: sv/b92c_pkg.sv
`timescale 1ns / 1ps

package b92c_pkg;

    // work kinds carried from the front to the back
    localparam logic [2:0] KIND_ENC4  = 3'd0;
    localparam logic [2:0] KIND_ENCS  = 3'd1;
    localparam logic [2:0] KIND_DEC5  = 3'd2;
    localparam logic [2:0] KIND_DEC2  = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam int DIGIT_W = 7;
    localparam int DATA_W  = 5 * DIGIT_W;

    // x / 23 == (x * DIV23_MAGIC) >> 35, exact for x < 2**30
    localparam logic [30:0] DIV23_MAGIC = 31'd1493901669;

    // powers of 92
    localparam logic [31:0] POW92_1 = 32'd92;
    localparam logic [31:0] POW92_2 = 32'd8464;
    localparam logic [31:0] POW92_3 = 32'd778688;
    localparam logic [31:0] POW92_4 = 32'd71639296;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [2:0]        kind;
        logic [2:0]        last_idx;
        logic [DATA_W-1:0] data;
    } cmd_t;

    function automatic logic [7:0] sym_of(input logic [6:0] d);
        logic [7:0] s;
        s = 8'h00;
        if (d inside {[7'd0:7'd25]})
        begin
            s = 8'h61 + {1'b0, d};
        end
        else if (d inside {[7'd26:7'd51]})
        begin
            s = 8'h41 + {1'b0, d} - 8'd26;
        end
        else if (d inside {[7'd52:7'd61]})
        begin
            s = 8'h30 + {1'b0, d} - 8'd52;
        end
        else
        begin
            case (d)
                7'd62: s = 8'h21;
                7'd63: s = 8'h24;
                7'd64: s = 8'h25;
                7'd65: s = 8'h5E;
                7'd66: s = 8'h26;
                7'd67: s = 8'h2A;
                7'd68: s = 8'h2D;
                7'd69: s = 8'h5F;
                7'd70: s = 8'h3D;
                7'd71: s = 8'h2B;
                7'd72: s = 8'h28;
                7'd73: s = 8'h29;
                7'd74: s = 8'h5B;
                7'd75: s = 8'h5D;
                7'd76: s = 8'h7B;
                7'd77: s = 8'h7D;
                7'd78: s = 8'h3C;
                7'd79: s = 8'h3E;
                7'd80: s = 8'h27;
                7'd81: s = 8'h40;
                7'd82: s = 8'h23;
                7'd83: s = 8'h7E;
                7'd84: s = 8'h3B;
                7'd85: s = 8'h3A;
                7'd86: s = 8'h2F;
                7'd87: s = 8'h3F;
                7'd88: s = 8'h2C;
                7'd89: s = 8'h2E;
                7'd90: s = 8'h7C;
                7'd91: s = 8'h5C;
                default: s = 8'h00;
            endcase
        end
        return s;
    endfunction

    // symbols outside the alphabet read as digit zero
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        logic [6:0] d;
        t = 8'h00;
        d = 7'd0;
        if (c inside {[8'h61:8'h7A]})
        begin
            t = c - 8'h61;
            d = t[6:0];
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            t = c - 8'h41 + 8'd26;
            d = t[6:0];
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            t = c - 8'h30 + 8'd52;
            d = t[6:0];
        end
        else
        begin
            case (c)
                8'h21: d = 7'd62;
                8'h24: d = 7'd63;
                8'h25: d = 7'd64;
                8'h5E: d = 7'd65;
                8'h26: d = 7'd66;
                8'h2A: d = 7'd67;
                8'h2D: d = 7'd68;
                8'h5F: d = 7'd69;
                8'h3D: d = 7'd70;
                8'h2B: d = 7'd71;
                8'h28: d = 7'd72;
                8'h29: d = 7'd73;
                8'h5B: d = 7'd74;
                8'h5D: d = 7'd75;
                8'h7B: d = 7'd76;
                8'h7D: d = 7'd77;
                8'h3C: d = 7'd78;
                8'h3E: d = 7'd79;
                8'h27: d = 7'd80;
                8'h40: d = 7'd81;
                8'h23: d = 7'd82;
                8'h7E: d = 7'd83;
                8'h3B: d = 7'd84;
                8'h3A: d = 7'd85;
                8'h2F: d = 7'd86;
                8'h3F: d = 7'd87;
                8'h2C: d = 7'd88;
                8'h2E: d = 7'd89;
                8'h7C: d = 7'd90;
                8'h5C: d = 7'd91;
                default: d = 7'd0;
            endcase
        end
        return d;
    endfunction

endpackage

// File: sv/b92c_front.sv
`timescale 1ns / 1ps

module b92c_front
(
    input  logic                direction,
    input  logic [7:0]          unit_a,
    input  logic [7:0]          unit_b,
    input  logic [7:0]          unit_c,
    input  logic [7:0]          unit_d,
    input  logic [7:0]          unit_e,
    input  logic [2:0]          unit_count,
    output b92c_pkg::cmd_t      cmd
);

    logic [6:0] dig_a;
    logic [6:0] dig_b;
    logic [6:0] dig_c;
    logic [6:0] dig_d;
    logic [6:0] dig_e;

    assign dig_a = b92c_pkg::digit_of(unit_a);
    assign dig_b = b92c_pkg::digit_of(unit_b);
    assign dig_c = b92c_pkg::digit_of(unit_c);
    assign dig_d = b92c_pkg::digit_of(unit_d);
    assign dig_e = b92c_pkg::digit_of(unit_e);

    always_comb
    begin
        cmd.kind     = b92c_pkg::KIND_ERR;
        cmd.last_idx = 3'd0;
        cmd.data     = '0;
        if (direction == b92c_pkg::DIR_ENCODE)
        begin
            cmd.data = {3'b000, unit_d, unit_c, unit_b, unit_a};
            if (unit_count == 3'd4)
            begin
                cmd.kind     = b92c_pkg::KIND_ENC4;
                cmd.last_idx = 3'd4;
            end
            else if (unit_count inside {[3'd1:3'd3]})
            begin
                // two symbols per byte
                cmd.kind     = b92c_pkg::KIND_ENCS;
                cmd.last_idx = {unit_count[1:0], 1'b0} - 3'd1;
            end
        end
        else
        begin
            cmd.data = {dig_e, dig_d, dig_c, dig_b, dig_a};
            if (unit_count == 3'd5)
            begin
                cmd.kind     = b92c_pkg::KIND_DEC5;
                cmd.last_idx = 3'd3;
            end
            else if (unit_count == 3'd2)
            begin
                cmd.kind = b92c_pkg::KIND_DEC2;
            end
        end
    end

endmodule

// File: sv/b92c_queue.sv
`timescale 1ns / 1ps

module b92c_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b92c_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output b92c_pkg::cmd_t      pop_cmd
);

    b92c_pkg::cmd_t mem [b92c_pkg::Q_DEPTH];

    logic [b92c_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [b92c_pkg::Q_PTR_W-1:0] wr_ptr_next;
    logic [b92c_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [b92c_pkg::Q_PTR_W-1:0] rd_ptr_next;
    logic [b92c_pkg::Q_CNT_W-1:0] cnt_reg;
    logic [b92c_pkg::Q_CNT_W-1:0] cnt_next;

    logic do_push;
    logic do_pop;

    assign full      = (cnt_reg == b92c_pkg::Q_CNT_W'(b92c_pkg::Q_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/b92c_back.sv
`timescale 1ns / 1ps

module b92c_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b92c_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_unit,
    output logic                run_end,
    output logic                count_error
);

    logic        active_reg;
    logic        active_next;
    logic [2:0]  kind_reg;
    logic [2:0]  kind_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [2:0]  last_idx_reg;
    logic [2:0]  last_idx_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_unit_reg;
    logic [7:0]  out_unit_next;
    logic        run_end_reg;
    logic        run_end_next;
    logic        count_error_reg;
    logic        count_error_next;

    logic        out_free;
    logic        emit;
    logic        last;

    // word / 92 == (word >> 2) / 23
    logic [60:0] prod;
    logic [25:0] quo;
    logic [31:0] quo32;
    logic [31:0] quo92;
    logic [31:0] rem32;

    // short encode: one byte split into low and high digit
    logic [7:0]  byte_cur;
    logic [1:0]  byte_hi;
    logic [7:0]  byte_lo8;

    logic [6:0]  ld0;
    logic [6:0]  ld1;
    logic [6:0]  ld2;
    logic [6:0]  ld3;
    logic [6:0]  ld4;
    logic [31:0] dec5_word;
    logic [31:0] dec2_word;
    logic [31:0] load_word;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = active_reg && out_free;
    assign last     = (idx_reg == last_idx_reg);
    assign q_pop    = q_valid && (!active_reg || (emit && last));

    assign prod  = 61'(word_reg[31:2]) * 61'(b92c_pkg::DIV23_MAGIC);
    assign quo   = prod[60:35];
    assign quo32 = {6'b000000, quo};
    assign quo92 = (quo32 << 6) + (quo32 << 4) + (quo32 << 3) + (quo32 << 2);
    assign rem32 = word_reg - quo92;

    assign byte_cur = word_reg[7:0];
    assign byte_hi  = (byte_cur >= 8'd184) ? 2'd2 : ((byte_cur >= 8'd92) ? 2'd1 : 2'd0);
    assign byte_lo8 = byte_cur - ((byte_hi == 2'd2) ? 8'd184 :
                                  ((byte_hi == 2'd1) ? 8'd92 : 8'd0));

    assign ld0 = q_cmd.data[6:0];
    assign ld1 = q_cmd.data[13:7];
    assign ld2 = q_cmd.data[20:14];
    assign ld3 = q_cmd.data[27:21];
    assign ld4 = q_cmd.data[34:28];

    // full group wraps modulo 2**32
    assign dec5_word = 32'(ld0) + 32'(ld1) * b92c_pkg::POW92_1
                     + 32'(ld2) * b92c_pkg::POW92_2
                     + 32'(ld3) * b92c_pkg::POW92_3
                     + 32'(ld4) * b92c_pkg::POW92_4;
    assign dec2_word = 32'(ld0) + 32'(ld1) * b92c_pkg::POW92_1;

    always_comb
    begin
        case (q_cmd.kind)
            b92c_pkg::KIND_ENC4: load_word = q_cmd.data[31:0];
            b92c_pkg::KIND_ENCS: load_word = q_cmd.data[31:0];
            b92c_pkg::KIND_DEC5: load_word = dec5_word;
            b92c_pkg::KIND_DEC2: load_word = {24'h000000, dec2_word[7:0]};
            default:             load_word = '0;
        endcase
    end

    always_comb
    begin
        active_next      = active_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        last_idx_next    = last_idx_reg;
        word_next        = word_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_unit_next    = out_unit_reg;
        run_end_next     = run_end_reg;
        count_error_next = count_error_reg;

        if (emit)
        begin
            out_valid_next   = 1'b1;
            run_end_next     = last;
            count_error_next = 1'b0;
            idx_next         = idx_reg + 3'd1;
            case (kind_reg)
                b92c_pkg::KIND_ENC4:
                begin
                    out_unit_next = b92c_pkg::sym_of(rem32[6:0]);
                    word_next     = quo32;
                end
                b92c_pkg::KIND_ENCS:
                begin
                    if (!idx_reg[0])
                    begin
                        out_unit_next = b92c_pkg::sym_of(byte_lo8[6:0]);
                    end
                    else
                    begin
                        out_unit_next = b92c_pkg::sym_of({5'b00000, byte_hi});
                        word_next     = word_reg >> 8;
                    end
                end
                b92c_pkg::KIND_DEC5:
                begin
                    out_unit_next = word_reg[7:0];
                    word_next     = word_reg >> 8;
                end
                b92c_pkg::KIND_DEC2:
                begin
                    out_unit_next = word_reg[7:0];
                end
                default:
                begin
                    out_unit_next    = 8'h00;
                    count_error_next = 1'b1;
                end
            endcase
            if (last)
            begin
                active_next = 1'b0;
            end
        end

        if (q_pop)
        begin
            active_next   = 1'b1;
            kind_next     = q_cmd.kind;
            idx_next      = 3'd0;
            last_idx_next = q_cmd.last_idx;
            word_next     = load_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        last_idx_reg    <= last_idx_next;
        word_reg        <= word_next;
        out_unit_reg    <= out_unit_next;
        run_end_reg     <= run_end_next;
        count_error_reg <= count_error_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_unit    = out_unit_reg;
    assign run_end     = run_end_reg;
    assign count_error = count_error_reg;

endmodule

// File: sv/base92_chunk_codec_unit.sv
`timescale 1ns / 1ps

// An item's first result passes the queue, the back's working registers and
// the output register. The back gives one result per cycle while out_stall is
// low and items wait: 5 results per four-byte encode, 2 per byte of a short
// encode, 4 per full-group decode, 1 per two-symbol decode or count error. A
// two-entry queue lets the front accept while the back works; out_stall holds
// the back. Reset: direction returns to encode, the queue empties, pending results drop.
module base92_chunk_codec_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_direction,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  unit_a,
    input  logic [7:0]  unit_b,
    input  logic [7:0]  unit_c,
    input  logic [7:0]  unit_d,
    input  logic [7:0]  unit_e,
    input  logic [2:0]  unit_count,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_unit,
    output logic        run_end,
    output logic        count_error
);

    logic           direction_reg;
    logic           direction_next;

    b92c_pkg::cmd_t front_cmd;
    b92c_pkg::cmd_t q_cmd;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        direction_next = direction_reg;
        if (cfg_valid && cfg_ready)
        begin
            direction_next = cfg_direction;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= b92c_pkg::DIR_ENCODE;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign in_stall = q_full;

    b92c_front u_front
    (
        .direction  (direction_reg),
        .unit_a     (unit_a),
        .unit_b     (unit_b),
        .unit_c     (unit_c),
        .unit_d     (unit_d),
        .unit_e     (unit_e),
        .unit_count (unit_count),
        .cmd        (front_cmd)
    );

    b92c_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    b92c_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_unit    (out_unit),
        .run_end     (run_end),
        .count_error (count_error)
    );

endmodule
